>>> hw/rtl/velocity_rescale_thermostat_top_assert.svh
// Assertion macros used by the controller RTL of the rescale thermostat.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef VELOCITY_RESCALE_THERMOSTAT_TOP_ASSERT_SVH
`define VELOCITY_RESCALE_THERMOSTAT_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define VRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define VRT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define VRT_ASSERT(lbl, prop, msg)
`define VRT_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> hw/rtl/vrt_pkg.sv
package vrt_pkg;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MOD,
    S_CHK,
    S_MUL_LO,
    S_MUL_HI,
    S_DIV_INIT,
    S_DIV,
    S_SQ_INIT,
    S_SQRT,
    S_SET,
    S_FIN
  } state_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_VEL,
    OP_MOD_INIT,
    OP_MOD_STEP,
    OP_MUL_PRE,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SQ_INIT,
    OP_SQ_STEP,
    OP_SET_ONE,
    OP_SET_ROOT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic out_load;
    logic applied;
  } ctl_t;

  typedef struct packed {
    logic mode;
    logic mod_zero;
    logic skip;
    logic sat;
  } sts_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_PERIOD  = 3'd0;
  localparam logic [2:0] CFG_PER_DOF = 3'd1;
  localparam logic [2:0] CFG_TOTAL   = 3'd2;
  localparam logic [2:0] CFG_KBT     = 3'd3;
  localparam logic [2:0] CFG_KB      = 3'd4;
  localparam logic [2:0] CFG_TEMP    = 3'd5;

  localparam logic [31:0] LAMBDA_ONE = 32'h0001_0000;

  localparam int CNT_W     = 6;
  localparam int MOD_STEPS = 32;
  localparam int DIV_STEPS = 64;
  localparam int SQ_STEPS  = 32;

endpackage

>>> hw/rtl/velocity_rescale_thermostat_top.sv
// Channel   Dir  Fields
// in_*      in   tuser: mode; tdata: timestep, energy, freedom_count, velocity_in
// out_*     out  tuser: item_kind; tdata: applied, zero_energy, config_error,
//                scale_factor, velocity_out
// cfg_*     in   index 0..5 of the six registers, 32-bit write data
//
// A velocity item is accepted, multiplied and then loaded into the result register,
// from which it is presented as valid.
// An event item runs 32 period-check steps; when lambda is recomputed it also runs
// 64 divide steps and 32 root steps, and the divide steps are skipped when the
// quotient saturates.
// One item is in work at a time; a waiting result does not block the next accept, it
// only holds the following item in its final stage until the result is taken.
// rst_n is synchronous and active low; lambda returns to 1.0.
module velocity_rescale_thermostat_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [119:0] in_tdata,  // timestep, energy, freedom_count, velocity_in
  input  logic         in_tuser,  // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata, // applied, zero_energy, config_error, scale_factor,
                                  // velocity_out, zero pad
  output logic         out_tuser, // item_kind
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);
  import vrt_pkg::*;

  ctl_t ctl;
  sts_t sts;

  vrt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .ctl        (ctl)
  );

  vrt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_mode   (in_tuser),
    .in_data   (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .kind      (out_tuser),
    .result    (out_tdata)
  );

endmodule

>>> hw/rtl/vrt_dp.sv
module vrt_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  vrt_pkg::ctl_t ctl,
  output vrt_pkg::sts_t sts,
  input  logic          in_mode,
  input  logic [119:0]  in_data,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_wdata,
  output logic          kind,
  output logic [71:0]   result
);
  import vrt_pkg::*;

  // configuration
  logic [30:0] period_r;
  logic [31:0] ped_r, tot_r, kbt_r, kb_r, tt_r;
  // latched item
  logic        mode_r;
  logic [31:0] ts_r, e_r;
  logic [23:0] dof_r;
  logic [31:0] v_r;
  // arithmetic state
  logic [55:0] a_r;
  logic [87:0] prod_r;
  logic [31:0] rem_r;
  logic [63:0] q_r;
  logic        sat_r;
  logic [35:0] srem_r;
  logic [31:0] root_r;
  logic [31:0] lambda_r;
  logic [63:0] vprod_r;
  // result
  logic        kind_r, app_r, zero_r, err_r;
  logic [31:0] scale_r, vel_r;

  logic        pd, tot, kbt, kb, tt, kbtt, temp_set, energy_on, bad;
  logic        sel_pd, sel_tot, sel_kbt;
  logic [31:0] tgt_b;
  logic [5:0]  shamt;
  logic [102:0] num;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [32:0] dvs, rem2, diff;
  logic        ge;
  logic [35:0] rem4, trial;
  logic        sq_ge;
  logic signed [64:0] vmul;
  logic signed [47:0] vq;
  logic [31:0] vsat;

  // settings check and target selection
  always_comb begin
    pd         = |ped_r;
    tot        = |tot_r;
    kbt        = |kbt_r;
    kb         = |kb_r;
    tt         = |tt_r;
    kbtt       = kb && tt;
    temp_set   = kbtt || kbt;
    energy_on  = pd || tot;
    bad        = (kb != tt) || (!energy_on && !temp_set) || (energy_on && temp_set) ||
                 (pd && tot) || (kbt && kbtt);
    sel_pd     = pd;
    sel_tot    = !pd && tot;
    sel_kbt    = !pd && !tot && kbt;
    if (sel_pd) begin
      tgt_b = ped_r;
      shamt = 6'd32;
    end else if (sel_tot) begin
      tgt_b = 32'd1;
      shamt = 6'd32;
    end else if (sel_kbt) begin
      tgt_b = kbt_r;
      shamt = 6'd31;
    end else begin
      tgt_b = tt_r;
      shamt = 6'd15;
    end
    num = 103'(prod_r) << shamt;
  end

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.op)
      OP_MUL_PRE: begin
        mul_a = {8'b0, dof_r};
        mul_b = kb_r;
      end
      OP_MUL_LO: begin
        mul_a = a_r[31:0];
        mul_b = tgt_b;
      end
      OP_MUL_HI: begin
        mul_a = {8'b0, a_r[55:32]};
        mul_b = tgt_b;
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  // restoring divide step, shared by the period check and the energy divide
  always_comb begin
    if (ctl.op == OP_MOD_STEP)
      dvs = (period_r == '0) ? 33'd1 : {2'b0, period_r};
    else
      dvs = {1'b0, e_r};
    rem2 = {rem_r, q_r[63]};
    ge   = rem2 >= dvs;
    diff = rem2 - dvs;
  end

  // square root step, two bits a step
  always_comb begin
    rem4  = {srem_r[33:0], q_r[63:62]};
    trial = {2'b0, root_r, 2'b01};
    sq_ge = rem4 >= trial;
  end

  // velocity product, floor shift and saturation
  always_comb begin
    vmul = $signed({{33{v_r[31]}}, v_r}) * $signed({33'b0, lambda_r});
    vq   = $signed(vprod_r[63:16]);
    if (vq[47:31] == '0 || vq[47:31] == '1)
      vsat = vq[31:0];
    else if (vq[47])
      vsat = 32'h8000_0000;
    else
      vsat = 32'h7FFF_FFFF;
  end

  // configuration writes and stored lambda
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= 31'd1;
      ped_r    <= '0;
      tot_r    <= '0;
      kbt_r    <= '0;
      kb_r     <= '0;
      tt_r     <= '0;
      lambda_r <= LAMBDA_ONE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PERIOD:  period_r <= cfg_wdata[30:0];
          CFG_PER_DOF: ped_r    <= cfg_wdata;
          CFG_TOTAL:   tot_r    <= cfg_wdata;
          CFG_KBT:     kbt_r    <= cfg_wdata;
          CFG_KB:      kb_r     <= cfg_wdata;
          CFG_TEMP:    tt_r     <= cfg_wdata;
          default: ;
        endcase
      end
      if (ctl.op == OP_SET_ONE)
        lambda_r <= LAMBDA_ONE;
      else if (ctl.op == OP_SET_ROOT)
        lambda_r <= root_r;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        mode_r <= in_mode;
        ts_r   <= in_data[31:0];
        e_r    <= in_data[63:32];
        dof_r  <= in_data[87:64];
        v_r    <= in_data[119:88];
      end
      OP_VEL: vprod_r <= vmul[63:0];
      OP_MOD_INIT: begin
        rem_r <= '0;
        q_r   <= {ts_r, 32'b0};
      end
      OP_MOD_STEP, OP_DIV_STEP: begin
        rem_r <= ge ? diff[31:0] : rem2[31:0];
        q_r   <= {q_r[62:0], ge};
      end
      OP_MUL_PRE: begin
        if (sel_pd || sel_kbt)
          a_r <= {32'b0, dof_r};
        else if (sel_tot)
          a_r <= {24'b0, tot_r};
        else
          a_r <= mul_p[55:0];
      end
      OP_MUL_LO: prod_r <= {24'b0, mul_p};
      OP_MUL_HI: prod_r <= prod_r + {mul_p[55:0], 32'b0};
      OP_DIV_INIT: begin
        if (num[102:64] >= {7'b0, e_r}) begin
          sat_r <= 1'b1;
          q_r   <= '1;
        end else begin
          sat_r <= 1'b0;
          rem_r <= num[95:64];
          q_r   <= num[63:0];
        end
      end
      OP_SQ_INIT: begin
        srem_r <= '0;
        root_r <= '0;
      end
      OP_SQ_STEP: begin
        srem_r <= sq_ge ? rem4 - trial : rem4;
        root_r <= {root_r[30:0], sq_ge};
        q_r    <= {q_r[61:0], 2'b00};
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      kind_r  <= mode_r;
      app_r   <= !mode_r && ctl.applied;
      zero_r  <= !mode_r && ctl.applied && (e_r == '0);
      err_r   <= !mode_r && bad;
      scale_r <= lambda_r;
      vel_r   <= mode_r ? vsat : '0;
    end
  end

  assign sts    = '{mode: mode_r, mod_zero: (rem_r == '0), skip: (bad || e_r == '0),
                    sat: sat_r};
  assign kind   = kind_r;
  assign result = {5'b0, vel_r, scale_r, err_r, zero_r, app_r};

endmodule

>>> hw/rtl/vrt_ctrl.sv
`include "velocity_rescale_thermostat_top_assert.svh"
module vrt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  vrt_pkg::sts_t sts,
  output vrt_pkg::ctl_t ctl
);
  import vrt_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             applied_r, applied_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             can_load;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      applied_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      applied_r   <= applied_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = '0;
    applied_nxt = applied_r;
    can_load    = !out_valid_r || out_tready;
    ctl         = '{op: OP_NONE, out_load: 1'b0, applied: applied_r};
    in_tready   = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctl.op    = OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        applied_nxt = 1'b0;
        if (sts.mode) begin
          ctl.op    = OP_VEL;
          state_nxt = S_FIN;
        end else begin
          ctl.op    = OP_MOD_INIT;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        ctl.op  = OP_MOD_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MOD_STEPS - 1))
          state_nxt = S_CHK;
      end
      S_CHK: begin
        applied_nxt = sts.mod_zero;
        if (!sts.mod_zero || sts.skip) begin
          ctl.op    = OP_SET_ONE;
          state_nxt = S_FIN;
        end else begin
          ctl.op    = OP_MUL_PRE;
          state_nxt = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        ctl.op    = OP_MUL_LO;
        state_nxt = S_MUL_HI;
      end
      S_MUL_HI: begin
        ctl.op    = OP_MUL_HI;
        state_nxt = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        ctl.op    = OP_DIV_INIT;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.sat) begin
          state_nxt = S_SQ_INIT;
        end else begin
          ctl.op  = OP_DIV_STEP;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DIV_STEPS - 1))
            state_nxt = S_SQ_INIT;
        end
      end
      S_SQ_INIT: begin
        ctl.op    = OP_SQ_INIT;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        ctl.op  = OP_SQ_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQ_STEPS - 1))
          state_nxt = S_SET;
      end
      S_SET: begin
        ctl.op    = OP_SET_ROOT;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the result register is free
        if (can_load) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (ctl.out_load)
      out_valid_nxt = 1'b1;
    else if (out_tready)
      out_valid_nxt = 1'b0;
    else
      out_valid_nxt = out_valid_r;
  end

  assign out_tvalid = out_valid_r;

  `VRT_ASSERT(a_no_overwrite, !ctl.out_load || !out_valid_r || out_tready, "result overwritten")
  `VRT_ASSERT_NEXT(a_div_to_sqrt, state_r == S_DIV && !sts.sat && cnt_r == CNT_W'(DIV_STEPS - 1), state_r == S_SQ_INIT, "divide did not hand over to root")
  `VRT_ASSERT_NEXT(a_root_after_sqrt, ctl.op == OP_SQ_STEP && cnt_r == CNT_W'(SQ_STEPS - 1), ctl.op == OP_SET_ROOT, "root not stored after last step")

endmodule

>>> dv/velocity_rescale_thermostat_top_tb.sv
`timescale 1ns / 100ps

module velocity_rescale_thermostat_top_tb;
  import vrt_pkg::*;

  localparam logic MODE_EVENT    = 1'b0;
  localparam logic MODE_VELOCITY = 1'b1;
  localparam int   IDLE_LIMIT    = 20000;
  localparam int   DRAIN_CYCLES  = 200;

  typedef struct {
    logic        mode;
    logic [31:0] timestep;
    logic [31:0] energy;
    logic [23:0] dof;
    logic [31:0] velocity;
  } thermo_item_t;

  typedef struct packed {
    logic        kind;
    logic        applied;
    logic        zero_energy;
    logic        config_error;
    logic [31:0] lambda;
    logic [31:0] velocity;
  } thermo_result_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [119:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [71:0]  out_tdata;
  logic         out_tuser;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_wdata;

  thermo_item_t   pending_items[$];
  thermo_result_t expected_results[$];

  // Local copy of the thermostat settings and lambda
  logic [30:0] period_q;
  logic [31:0] per_dof_q, total_q, kbt_q, kb_q, temp_q;
  logic [31:0] lambda_q;

  int  mismatches;
  int  idle_cycles;
  bit  in_accepted;
  bit  no_idle;
  int  in_gap;
  int  out_gap;

  velocity_rescale_thermostat_top DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 55) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 15);
  endfunction

  function automatic logic [31:0] isqrt64(logic [63:0] x);
    logic [31:0] r;
    logic [31:0] trial;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (32'd1 << b);
      if ({32'd0, trial} * {32'd0, trial} <= x) r = trial;
    end
    return r;
  endfunction

  function automatic bit targets_bad();
    bit pd, tot, kbt, kb, tt, kbtt, temp_set, energy_on;
    pd = per_dof_q != 0;
    tot = total_q != 0;
    kbt = kbt_q != 0;
    kb = kb_q != 0;
    tt = temp_q != 0;
    kbtt = kb && tt;
    temp_set = kbtt || kbt;
    energy_on = pd || tot;
    if (kb != tt) return 1;
    if (!energy_on && !temp_set) return 1;
    if (energy_on && temp_set) return 1;
    if (pd && tot) return 1;
    if (kbt && kbtt) return 1;
    return 0;
  endfunction

  // Lambda = floor(sqrt(target * 2^s / E)), saturated when the ratio overflows 64 bits
  function automatic logic [31:0] target_lambda(logic [31:0] e, logic [23:0] dof);
    logic [127:0] num;
    logic [127:0] ratio;
    if (per_dof_q != 0) num = (128'(dof) * per_dof_q) << 32;
    else if (total_q != 0) num = 128'(total_q) << 32;
    else if (kbt_q != 0) num = (128'(dof) * kbt_q) << 31;
    else num = (128'(dof) * kb_q * temp_q) << 15;
    ratio = num / e;
    if (ratio[127:64] != 0) return 32'hFFFF_FFFF;
    return isqrt64(ratio[63:0]);
  endfunction

  function automatic thermo_result_t predict_thermostat(thermo_item_t it);
    thermo_result_t res;
    logic [31:0] period;
    logic signed [63:0] prod;
    logic signed [63:0] quo;
    bit bad;
    res = '{it.mode, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0};
    if (it.mode == MODE_EVENT) begin
      period = (period_q == 0) ? 32'd1 : {1'b0, period_q};
      bad = targets_bad();
      res.config_error = bad;
      if (it.timestep % period == 0) begin
        res.applied = 1'b1;
        res.zero_energy = (it.energy == 0);
        if (bad || it.energy == 0) lambda_q = LAMBDA_ONE;
        else lambda_q = target_lambda(it.energy, it.dof);
      end else begin
        lambda_q = LAMBDA_ONE;
      end
    end else begin
      prod = 64'(signed'(it.velocity)) * signed'({32'd0, lambda_q});
      quo = prod >>> 16;
      if (quo > 64'sd2147483647) res.velocity = 32'h7FFF_FFFF;
      else if (quo < -64'sd2147483648) res.velocity = 32'h8000_0000;
      else res.velocity = quo[31:0];
    end
    res.lambda = lambda_q;
    return res;
  endfunction

  // Write one register at a falling edge, block is idle
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_PERIOD:  period_q = val[30:0];
      CFG_PER_DOF: per_dof_q = val;
      CFG_TOTAL:   total_q = val;
      CFG_KBT:     kbt_q = val;
      CFG_KB:      kb_q = val;
      CFG_TEMP:    temp_q = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_thermostat(logic [31:0] period, logic [31:0] pd, logic [31:0] tot,
                                logic [31:0] kbt, logic [31:0] kb, logic [31:0] tt);
    write_reg(CFG_PERIOD, period);
    write_reg(CFG_PER_DOF, pd);
    write_reg(CFG_TOTAL, tot);
    write_reg(CFG_KBT, kbt);
    write_reg(CFG_KB, kb);
    write_reg(CFG_TEMP, tt);
  endtask

  task automatic push_item(logic mode, logic [31:0] ts, logic [31:0] e, logic [23:0] dof,
                           logic [31:0] vel);
    thermo_item_t it;
    it = '{mode, ts, e, dof, vel};
    pending_items.push_back(it);
  endtask

  // Mostly velocities, with events on and off the rescale grid
  task automatic queue_random(int count);
    logic [31:0] per;
    logic [31:0] ts, e, v;
    logic [23:0] dof;
    per = (period_q == 0) ? 32'd1 : {1'b0, period_q};
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 20) begin
        case ($urandom_range(3))
          0: ts = $urandom;
          1: ts = 32'd0;
          default: ts = per * $urandom_range(7);
        endcase
        case ($urandom_range(5))
          0: e = 32'd0;
          1: e = $urandom_range(255, 1);
          2: e = $urandom;
          default: e = $urandom_range(32'h00FF_FFFF, 32'h100);
        endcase
        dof = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(300));
        push_item(MODE_EVENT, ts, e, dof, $urandom);
      end else begin
        v = ($urandom_range(2) == 0) ? $urandom : 32'($signed($urandom_range(1 << 20)) - (1 << 19));
        push_item(MODE_VELOCITY, $urandom, $urandom, 24'($urandom), v);
      end
    end
  endtask

  // Wait at rising edges until nothing is queued, driven or outstanding
  task automatic wait_drained();
    do
      @(posedge clk);
    while (pending_items.size() != 0 || expected_results.size() != 0 || in_tvalid);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Input driver: hold the transaction until it is taken, then insert a gap
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_accepted)) begin
      in_accepted = 0;
      if (in_gap > 0 || pending_items.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_tvalid <= 1'b0;
      end else begin
        thermo_item_t it;
        it = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= it.mode;
        in_tdata <= {it.velocity, it.dof, it.energy, it.timestep};
        in_gap = pick_gap();
      end
    end
  end

  // Result backpressure
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!no_idle && $urandom_range(3) == 0) out_gap = pick_gap();
    end
  end

  // Monitor: predict on accept, compare on result, watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      idle_cycles++;
      if (in_tvalid && in_tready) begin
        thermo_item_t it;
        it.mode = in_tuser;
        it.timestep = in_tdata[31:0];
        it.energy = in_tdata[63:32];
        it.dof = in_tdata[87:64];
        it.velocity = in_tdata[119:88];
        expected_results.push_back(predict_thermostat(it));
        in_accepted = 1;
        idle_cycles = 0;
      end
      if (out_tvalid && out_tready) begin
        thermo_result_t exp_r;
        thermo_result_t act;
        idle_cycles = 0;
        act = '{out_tuser, out_tdata[0], out_tdata[1], out_tdata[2], out_tdata[34:3],
                out_tdata[66:35]};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind %0b lambda %h vel %h",
                     act.kind, act.lambda, act.velocity);
        end else begin
          exp_r = expected_results.pop_front();
          if (act != exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp kind %0b app %0b zero %0b err %0b lam %h vel %h / act %0b %0b %0b %0b %h %h",
                       exp_r.kind, exp_r.applied, exp_r.zero_energy, exp_r.config_error,
                       exp_r.lambda, exp_r.velocity, act.kind, act.applied,
                       act.zero_energy, act.config_error, act.lambda, act.velocity);
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("velocity_rescale_thermostat_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    mismatches = 0;
    idle_cycles = 0;
    in_gap = 0;
    out_gap = 0;
    no_idle = 0;
    period_q = 31'd1;
    {per_dof_q, total_q, kbt_q, kb_q, temp_q} = '0;
    lambda_q = LAMBDA_ONE;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings give a config error, lambda stays 1.0
    push_item(MODE_VELOCITY, 0, 0, 0, 32'h7FFF_FFFF);
    push_item(MODE_VELOCITY, 0, 0, 0, 32'h8000_0000);
    push_item(MODE_EVENT, 32'd5, 32'h0001_0000, 24'd3, 0);
    push_item(MODE_VELOCITY, 0, 0, 0, 32'hFFFF_FFFF);
    wait_drained();

    // Directed: per-dof target, zero energy, zero dof, saturation, off-grid event
    set_thermostat(32'd4, 32'h0002_0000, 0, 0, 0, 0);
    push_item(MODE_EVENT, 32'd8, 32'h0004_0000, 24'd2, 0);
    push_item(MODE_VELOCITY, 0, 0, 0, 32'h0003_0000);
    push_item(MODE_EVENT, 32'd0, 32'd0, 24'd2, 0);
    push_item(MODE_EVENT, 32'd4, 32'h0001_0000, 24'd0, 0);
    push_item(MODE_VELOCITY, 0, 0, 0, 32'h7FFF_FFFF);
    push_item(MODE_EVENT, 32'hFFFF_FFFC, 32'd1, 24'hFF_FFFF, 0);
    push_item(MODE_VELOCITY, 0, 0, 0, 32'h7FFF_FFFF);
    push_item(MODE_VELOCITY, 0, 0, 0, 32'h8000_0000);
    push_item(MODE_VELOCITY, 0, 0, 0, 32'hFFFF_FFFF);
    push_item(MODE_EVENT, 32'd7, 32'h0001_0000, 24'd2, 0);
    push_item(MODE_VELOCITY, 0, 0, 0, 32'h1234_5678);
    wait_drained();

    // Directed: period zero, kb and temperature targets, conflicts
    set_thermostat(32'd0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(MODE_EVENT, 32'd3, 32'hFFFF_FFFF, 24'hFF_FFFF, 0);
    push_item(MODE_VELOCITY, 0, 0, 0, 32'hFFFF_0000);
    wait_drained();
    set_thermostat(32'h7FFF_FFFF, 0, 0, 32'h0001_0000, 32'h10, 0);
    push_item(MODE_EVENT, 32'd0, 32'h0001_0000, 24'd10, 0);
    wait_drained();

    // Random phases across the target kinds and period extremes
    for (int ph = 0; ph < 10; ph++) begin
      logic [31:0] per;
      per = (ph == 3) ? 32'h7FFF_FFFF : (ph == 6) ? 32'd0 : $urandom_range(5, 1);
      no_idle = (ph % 4 == 1);
      case (ph % 6)
        0: set_thermostat(per, $urandom, 0, 0, 0, 0);
        1: set_thermostat(per, 0, $urandom, 0, 0, 0);
        2: set_thermostat(per, 0, 0, $urandom, 0, 0);
        3: set_thermostat(per, 0, 0, 0, $urandom_range(32'h0002_0000), $urandom);
        4: set_thermostat(per, $urandom_range(1) ? $urandom : 0, $urandom, $urandom,
                          $urandom_range(1) ? $urandom : 0, $urandom_range(1) ? $urandom : 0);
        default: set_thermostat(per, 0, 0, 32'hFFFF_FFFF, 0, 0);
      endcase
      queue_random(120);
      wait_drained();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("velocity_rescale_thermostat_top regression: pass");
    end else begin
      $display("velocity_rescale_thermostat_top regression: fail");
    end
    $finish;
  end

endmodule
